// File: src/skt_pkg.sv
// Package for the sorted key table: sizes, operation and status codes, and
// the structs passed between the controller, the cell row and the collector.
// Depends on nothing.
package skt_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;

  // Wide enough to hold any position and the count itself.
  localparam int POS_W = $clog2(CAPACITY + 1);
  // Register levels in the collection tree.
  localparam int DEPTH = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_FULL      = 3'd3,
    STS_RANGE     = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // What a selected cell offers to the collector; unselected cells give zero.
  typedef struct packed {
    logic             any;
    logic             hit;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } leaf_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic             rem_en;
    logic             wr_en;
    logic             by_index;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] count;
    entry_t           ent;
  } cmd_t;

endpackage

// File: src/sorted_key_table.sv
// Top level of the sorted key table: request and result registers, control
// sequencer, the row of cells and the collection tree.
// Depends on skt_pkg, skt_cell and skt_collect.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   request  | in_valid, in_stall  | operation, search_key, entry_index, payload_in
//   result   | out_valid, out_stall| status, position, key_out, payload_out, entry_count
//
// A lookup, insert, remove, read or write passes from accept through the
// compare state in every cell, the collect state while the registered
// collection tree settles, the apply state to decide and shift, and the
// result state to load the result register. Clear and the unused codes
// skip compare and collect. One request is worked on at a time; the next
// is taken in the cycle after its result is loaded. Reset empties the
// table at once; stored entries are left as they are. A stalled result
// holds the sequencer in its final state until the result register is free.
module sorted_key_table import skt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] search_key,
  input  logic [7:0]  entry_index,
  input  logic [31:0] payload_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [8:0]  position,
  output logic [31:0] key_out,
  output logic [31:0] payload_out,
  output logic [8:0]  entry_count
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_COMPARE = 5'b00010,
    S_COLLECT = 5'b00100,
    S_APPLY   = 5'b01000,
    S_RESULT  = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] valid_count;
  logic [POS_W-1:0] valid_count_next;

  // The accepted request.
  op_t              req_op;
  logic [KEY_W-1:0] req_key;
  logic [7:0]       req_idx;
  logic [PAY_W-1:0] req_pay;

  // The result held until the output register is free.
  status_t          res_status;
  logic [POS_W-1:0] res_pos;
  logic [KEY_W-1:0] res_key;
  logic [PAY_W-1:0] res_pay;
  status_t          res_status_next;
  logic [POS_W-1:0] res_pos_next;
  logic [KEY_W-1:0] res_key_next;
  logic [PAY_W-1:0] res_pay_next;

  logic             accept;
  logic             out_free;
  logic             by_index;
  logic             idx_in_range;
  logic [POS_W-1:0] srch_pos;
  logic             do_ins;
  logic             do_rem;
  logic             do_wr;
  cmd_t             cmd;
  leaf_t            root;

  entry_t           ents   [CAPACITY];
  logic             lts    [CAPACITY];
  leaf_t            leaves [CAPACITY];

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign by_index     = (req_op == OP_READ) || (req_op == OP_WRITE);
  assign idx_in_range = 32'(req_idx) < 32'(valid_count);
  // With no boundary cell every stored key is below the search key.
  assign srch_pos     = root.any ? root.pos : valid_count;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= op_t'(operation);
      req_key <= KEY_W'(search_key);
      req_idx <= entry_index;
      req_pay <= PAY_W'(payload_in);
    end
  end

  // Decision on the collected entry; its effect is taken in the apply state.
  always_comb begin
    res_status_next  = STS_OK;
    res_pos_next     = '0;
    res_key_next     = '0;
    res_pay_next     = '0;
    valid_count_next = valid_count;
    do_ins           = 1'b0;
    do_rem           = 1'b0;
    do_wr            = 1'b0;
    unique case (req_op)
      OP_LOOKUP: begin
        res_pos_next = srch_pos;
        if (root.hit) begin
          res_key_next = root.key;
          res_pay_next = root.pay;
        end else begin
          res_status_next = STS_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        res_pos_next = srch_pos;
        if (root.hit) begin
          res_status_next = STS_DUPLICATE;
        end else if (valid_count == POS_W'(CAPACITY)) begin
          res_status_next = STS_FULL;
        end else begin
          do_ins           = 1'b1;
          valid_count_next = valid_count + 1'b1;
          res_key_next     = req_key;
          res_pay_next     = req_pay;
        end
      end
      OP_REMOVE: begin
        res_pos_next = srch_pos;
        if (root.hit) begin
          do_rem           = 1'b1;
          valid_count_next = valid_count - 1'b1;
          res_key_next     = root.key;
          res_pay_next     = root.pay;
        end else begin
          res_status_next = STS_NOT_FOUND;
        end
      end
      OP_READ, OP_WRITE: begin
        res_pos_next = POS_W'(req_idx);
        if (idx_in_range) begin
          do_wr        = (req_op == OP_WRITE);
          res_key_next = root.key;
          res_pay_next = (req_op == OP_WRITE) ? req_pay : root.pay;
        end else begin
          res_status_next = STS_RANGE;
        end
      end
      OP_CLEAR: begin
        valid_count_next = '0;
      end
      default: begin
        // Unused codes leave the table as it is.
      end
    endcase
  end

  // Broadcast to the cell row. In index mode the position is the requested
  // index throughout; in search mode it is the boundary found.
  always_comb begin
    cmd          = '0;
    cmd.cmp_en   = (state == S_COMPARE);
    cmd.ins_en   = (state == S_APPLY) && do_ins;
    cmd.rem_en   = (state == S_APPLY) && do_rem;
    cmd.wr_en    = (state == S_APPLY) && do_wr;
    cmd.by_index = by_index;
    cmd.pos      = by_index ? POS_W'(req_idx) : srch_pos;
    cmd.count    = valid_count;
    cmd.ent.key  = req_key;
    cmd.ent.pay  = req_pay;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((op_t'(operation) == OP_LOOKUP) || (op_t'(operation) == OP_INSERT) ||
              (op_t'(operation) == OP_REMOVE) || (op_t'(operation) == OP_READ) ||
              (op_t'(operation) == OP_WRITE)) begin
            state_next = S_COMPARE;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_COMPARE: state_next = S_COLLECT;
      S_COLLECT: begin
        if (cnt == CNT_W'(DEPTH - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      valid_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_COLLECT) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == S_APPLY) begin
        valid_count <= valid_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      res_status <= res_status_next;
      res_pos    <= res_pos_next;
      res_key    <= res_key_next;
      res_pay    <= res_pay_next;
    end
  end

  // Result register: entry_count is the count after the operation, which has
  // already been taken when the sequencer reaches its final state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      status      <= res_status;
      position    <= 9'(res_pos);
      key_out     <= 32'(res_key);
      payload_out <= 32'(res_pay);
      entry_count <= 9'(valid_count);
    end
  end

  // The row of cells. The first cell sees a set less-than flag on its left so
  // that it becomes the boundary when its own key is not below the search key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_lt;

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_ent = ents[i-1];
      assign left_lt  = lts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_index (POS_W'(i)),
      .left_ent   (left_ent),
      .right_ent  (right_ent),
      .left_lt    (left_lt),
      .ent        (ents[i]),
      .lt         (lts[i]),
      .leaf       (leaves[i])
    );
  end

  skt_collect u_collect (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  // The count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= POS_W'(CAPACITY))
    else $error("entry count above capacity");

  // A successful insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_en |=> valid_count == POS_W'($past(valid_count) + 1'b1))
    else $error("insert did not grow the table by one");

  // A successful remove shrinks the table by exactly one entry.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_en |=> valid_count == POS_W'($past(valid_count) - 1'b1))
    else $error("remove did not shrink the table by one");

  // A result appears only from the final sequencer state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("result shown outside the final state");

  // Every search passes through the collection tree after its compare cycle.
  a_compare_then_collect: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPARE |=> state == S_COLLECT)
    else $error("compare not followed by collection");

endmodule

// File: src/skt_cell.sv
// One cell of the sorted key table: holds one entry, compares it with the
// broadcast key and shifts entries to or from its neighbours.
// Depends on skt_pkg.
module skt_cell import skt_pkg::*; (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [POS_W-1:0] cell_index,
  input  entry_t           left_ent,
  input  entry_t           right_ent,
  input  logic             left_lt,
  output entry_t           ent,
  output logic             lt,
  output leaf_t            leaf
);

  logic eq;
  logic valid;
  logic sel;

  assign valid = cell_index < cmd.count;

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      lt <= valid && (ent.key < cmd.ent.key);
      eq <= (ent.key == cmd.ent.key);
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.ins_en && (cell_index > cmd.pos)) begin
      ent <= left_ent;
    end else if (cmd.ins_en && (cell_index == cmd.pos)) begin
      ent <= cmd.ent;
    end else if (cmd.rem_en && (cell_index >= cmd.pos)) begin
      ent <= right_ent;
    end else if (cmd.wr_en && (cell_index == cmd.pos)) begin
      ent.pay <= cmd.ent.pay;
    end else begin
      ent <= ent;
    end
  end

  // The keys below the count are sorted, so the less-than flags form a
  // thermometer; the search boundary is where the left flag is set and ours
  // is not.
  assign sel = cmd.by_index ? (cell_index == cmd.pos) : (left_lt && !lt);

  always_comb begin
    leaf = '0;
    if (sel) begin
      leaf.any = 1'b1;
      leaf.hit = valid && eq;
      leaf.pos = cell_index;
      leaf.key = ent.key;
      leaf.pay = ent.pay;
    end
  end

endmodule

// File: src/skt_collect.sv
// Registered OR tree that gathers the single selected leaf of the cell row.
// Every level of the tree is registered; the root is the output of the top node.
// Depends on skt_pkg.
module skt_collect import skt_pkg::*; (
  input  logic  clk,
  input  leaf_t leaves [CAPACITY],
  output leaf_t root
);

  leaf_t node [CAPACITY-1];

  for (genvar n = 0; n < CAPACITY - 1; n++) begin : g_node
    localparam int LC = 2 * n + 1;
    localparam int RC = 2 * n + 2;
    leaf_t lsrc;
    leaf_t rsrc;

    if (LC >= CAPACITY - 1) begin : g_lleaf
      assign lsrc = leaves[LC-(CAPACITY-1)];
    end else begin : g_lnode
      assign lsrc = node[LC];
    end

    if (RC >= CAPACITY - 1) begin : g_rleaf
      assign rsrc = leaves[RC-(CAPACITY-1)];
    end else begin : g_rnode
      assign rsrc = node[RC];
    end

    always_ff @(posedge clk) begin
      node[n] <= leaf_t'(lsrc | rsrc);
    end
  end

  assign root = node[0];

endmodule

// File: bench/tb_sorted_key_table.sv
// Self-checking testbench for sorted_key_table: a clocked driver and monitor
// around the block, with a behavioural copy of the table predicting every result.
// Depends on skt_pkg and on the sorted_key_table RTL.
module tb_sorted_key_table import skt_pkg::*; ();

  // Codes six and seven are not operations; the block must ignore them.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Random requests that do something, on top of the directed and fill parts.
  localparam int RANDOM_REQUESTS = 1000;
  // The long receiver hold-off starts once this many results have come back.
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  // The longest legal quiet spell comes from the receiver hold-off, so this
  // leaves a wide margin.
  localparam int QUIET_LIMIT = 3000;
  // Cycles to watch for stray results once nothing is outstanding.
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_DEPTH   = 128;

  typedef struct {
    logic [2:0]       op;
    logic [KEY_W-1:0] key;
    logic [7:0]       idx;
    logic [PAY_W-1:0] pay;
  } request_t;

  typedef struct {
    status_t          status;
    logic [8:0]       position;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [8:0]       count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = OP_LOOKUP;
  logic [31:0] search_key = '0;
  logic [7:0]  entry_index = '0;
  logic [31:0] payload_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [8:0]  position;
  logic [31:0] key_out;
  logic [31:0] payload_out;
  logic [8:0]  entry_count;

  sorted_key_table uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .search_key(search_key),
    .entry_index(entry_index),
    .payload_in(payload_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .position(position),
    .key_out(key_out),
    .payload_out(payload_out),
    .entry_count(entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the table, advanced once per accepted request.
  logic [KEY_W-1:0] tbl_key [CAPACITY];
  logic [PAY_W-1:0] tbl_pay [CAPACITY];
  int               tbl_count = 0;

  request_t         pending_reqs[$];   // requests not yet offered to the block
  reply_t           awaited[$];        // predicted results, oldest first
  logic [KEY_W-1:0] key_pool[$];       // keys inserted lately, reused for hits

  int fail_count   = 0;
  int replies_seen = 0;
  int quiet_cycles = 0;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  logic req_fire   = 1'b0;
  logic reply_fire = 1'b0;

  // First position whose key is not below k: where k sits or would go.
  function automatic int find_slot(logic [KEY_W-1:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request to the table copy and returns the result it must give.
  function automatic reply_t apply_table_op(request_t req);
    reply_t r;
    int     slot, i;
    logic   hit;
    r.status   = STS_OK;
    r.position = '0;
    r.key      = '0;
    r.pay      = '0;
    case (req.op)
      OP_LOOKUP, OP_INSERT, OP_REMOVE: begin
        slot = find_slot(req.key);
        hit = (slot < tbl_count) && (tbl_key[slot] == req.key);
        r.position = slot[8:0];
        if (req.op == OP_LOOKUP) begin
          if (hit) begin
            r.key = tbl_key[slot];
            r.pay = tbl_pay[slot];
          end else begin
            r.status = STS_NOT_FOUND;
          end
        end else if (req.op == OP_INSERT) begin
          // A duplicate key is reported even when the table is full.
          if (hit) begin
            r.status = STS_DUPLICATE;
          end else if (tbl_count >= CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            for (i = tbl_count; i > slot; i--) begin
              tbl_key[i] = tbl_key[i-1];
              tbl_pay[i] = tbl_pay[i-1];
            end
            tbl_key[slot] = req.key;
            tbl_pay[slot] = req.pay;
            tbl_count++;
            r.key = req.key;
            r.pay = req.pay;
          end
        end else if (!hit) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.key = tbl_key[slot];
          r.pay = tbl_pay[slot];
          for (i = slot; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
        end
      end
      OP_READ, OP_WRITE: begin
        r.position = {1'b0, req.idx};
        if (req.idx >= tbl_count) begin
          r.status = STS_RANGE;
        end else begin
          if (req.op == OP_WRITE) tbl_pay[req.idx] = req.pay;
          r.key = tbl_key[req.idx];
          r.pay = tbl_pay[req.idx];
        end
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.count = tbl_count[8:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic queue_request(logic [2:0] op, logic [KEY_W-1:0] key, logic [7:0] idx,
                               logic [PAY_W-1:0] pay);
    request_t req;
    req.op  = op;
    req.key = key;
    req.idx = idx;
    req.pay = pay;
    pending_reqs.push_back(req);
    if (op == OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // Mostly keys that were inserted lately, so that lookups and removes hit
  // and inserts collide; the rest are the extremes or anything at all.
  function automatic logic [KEY_W-1:0] pick_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6 && key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick == 6) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Monitor: checks each result against the oldest prediction and predicts
  // each accepted request. Both are sampled at the rising edge, so the
  // values seen are those from before the block's own updates.
  reply_t   want_reply;
  request_t seen_req;

  always @(posedge clk) begin
    if (rst) begin
      req_fire   <= 1'b0;
      reply_fire <= 1'b0;
    end else begin
      req_fire   <= in_valid && !in_stall;
      reply_fire <= out_valid && !out_stall;
      // The result is checked first: a result and the next request can share
      // an edge, and the result always belongs to the earlier request.
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited.size() == 0) begin
          $error("result with no request outstanding: status %0d, position %0d",
                 status, position);
          fail_count++;
        end else begin
          want_reply = awaited.pop_front();
          check_field("status", want_reply.status, status);
          check_field("position", want_reply.position, position);
          check_field("key_out", want_reply.key, key_out);
          check_field("payload_out", want_reply.pay, payload_out);
          check_field("entry_count", want_reply.count, entry_count);
        end
      end
      if (in_valid && !in_stall) begin
        seen_req.op  = operation;
        seen_req.key = search_key;
        seen_req.idx = entry_index;
        seen_req.pay = payload_in;
        awaited.push_back(apply_table_op(seen_req));
      end
      // Watchdog: a hang shows up as a long spell with no handshake at all.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no request or result accepted for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Request driver. After each accepted request it draws a random gap; it
  // runs stretches of random gaps and calm stretches with none, so
  // back-to-back requests are exercised as well.
  request_t next_req;
  int       send_wait = 0;
  int       send_calm_left = 0;
  logic     send_calm = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (req_fire) begin
        if (send_calm_left == 0) begin
          send_calm = ($urandom_range(0, 2) == 0);
          send_calm_left = $urandom_range(20, 60);
        end
        send_calm_left--;
        send_wait = send_calm ? 0 : $urandom_range(0, 10);
      end
      if (send_wait != 0 || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
        if (send_wait != 0) send_wait--;
      end else begin
        next_req = pending_reqs.pop_front();
        in_valid    <= 1'b1;
        operation   <= next_req.op;
        search_key  <= next_req.key;
        entry_index <= next_req.idx;
        payload_in  <= next_req.pay;
      end
    end
  end

  // Result receiver. Stalls for a random spell before each result, with
  // calm stretches in between, and once holds off for a long spell while
  // requests keep coming, so that the block backs up and stalls its input.
  int   recv_wait = 0;
  int   recv_calm_left = 0;
  logic recv_calm = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (reply_fire) begin
        if (recv_calm_left == 0) begin
          recv_calm = ($urandom_range(0, 2) == 0);
          recv_calm_left = $urandom_range(20, 60);
        end
        recv_calm_left--;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 10);
        if (!hold_done && replies_seen >= HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed requests, a fill of the table to capacity, then
  // random traffic. Everything is queued up front; the driver paces it.
  initial begin : stimulus
    logic [7:0]       high_byte [256];
    logic [7:0]       swap;
    logic [2:0]       op;
    logic [7:0]       idx;
    int               i, j, pick, useful;

    // Empty table: misses, out-of-range accesses at both index extremes.
    queue_request(OP_LOOKUP, 32'h0000_1234, 8'd0, 32'h0);
    queue_request(OP_REMOVE, 32'h0000_1234, 8'd0, 32'h0);
    queue_request(OP_READ, 32'h0, 8'd0, 32'h0);
    queue_request(OP_WRITE, 32'h0, 8'd255, 32'hFFFF_FFFF);
    // Inserts at the middle, the front and the end, then a duplicate.
    queue_request(OP_INSERT, 32'h8000_0000, 8'd0, 32'hA5A5_A5A5);
    queue_request(OP_INSERT, 32'h0000_0000, 8'd0, 32'h0000_0000);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 32'h8000_0000, 8'd0, 32'h1234_5678);
    // Hits at both key extremes and a miss that falls between entries.
    queue_request(OP_LOOKUP, 32'h0000_0000, 8'd0, 32'h0);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0, 32'h0);
    queue_request(OP_LOOKUP, 32'h7FFF_FFFF, 8'd0, 32'h0);
    // Reads at the last valid entry and just past it, then a payload write.
    queue_request(OP_READ, 32'h0, 8'd2, 32'h0);
    queue_request(OP_READ, 32'h0, 8'd3, 32'h0);
    queue_request(OP_WRITE, 32'h0, 8'd1, 32'h5A5A_5A5A);
    queue_request(OP_LOOKUP, 32'h8000_0000, 8'd0, 32'h0);
    // Remove the middle entry, then try again for a miss.
    queue_request(OP_REMOVE, 32'h8000_0000, 8'd0, 32'h0);
    queue_request(OP_REMOVE, 32'h8000_0000, 8'd0, 32'h0);
    // Undefined codes must leave the table alone.
    queue_request(OP_SPARE_LO, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    queue_request(OP_SPARE_HI, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 32'h0000_0001, 8'd0, 32'h0000_0001);
    queue_request(OP_INSERT, 32'hFFFF_FFFE, 8'd0, 32'hFFFF_FFFE);
    queue_request(OP_READ, 32'h0, 8'd255, 32'h0);
    queue_request(OP_CLEAR, 32'h0, 8'd0, 32'h0);
    queue_request(OP_LOOKUP, 32'h0000_0000, 8'd0, 32'h0);
    queue_request(OP_READ, 32'h0, 8'd0, 32'h0);

    // Fill to capacity in shuffled order; distinct top bytes keep keys unique
    // while the positions of the inserts land all over the table.
    for (i = 0; i < 256; i++) high_byte[i] = i[7:0];
    for (i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = high_byte[i];
      high_byte[i] = high_byte[j];
      high_byte[j] = swap;
    end
    for (i = 0; i < CAPACITY; i++)
      queue_request(OP_INSERT, {high_byte[i], 24'($urandom)}, 8'($urandom), $urandom);
    // Full table: new keys are refused, also the last of them sent again,
    // and the top index is now in range.
    for (i = 0; i < 3; i++) queue_request(OP_INSERT, $urandom, 8'd0, $urandom);
    queue_request(OP_INSERT, key_pool[key_pool.size() - 1], 8'd0, $urandom);
    queue_request(OP_READ, 32'h0, 8'd255, 32'h0);
    queue_request(OP_WRITE, 32'h0, 8'd255, $urandom);
    queue_request(OP_READ, 32'h0, 8'd0, 32'h0);

    // Random traffic with lookups the most common operation and a rare clear.
    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_LOOKUP;
      else if (pick < 55) op = OP_INSERT;
      else if (pick < 75) op = OP_REMOVE;
      else if (pick < 86) op = OP_READ;
      else if (pick < 97) op = OP_WRITE;
      else if (pick < 98) op = OP_CLEAR;
      else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      // Half the indices are small so that reads land in range on a thin table.
      idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      queue_request(op, pick_key(), idx, $urandom);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) useful++;
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
